// ===== rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int DataW    = 32;
    localparam int NumVars  = 26;
    localparam int VarIdxW  = 5;
    localparam int QuoW     = 48;
    localparam int DivCntW  = 6;

    // opcodes
    localparam logic [3:0] OP_PUSH   = 4'd0;
    localparam logic [3:0] OP_ADD    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_DIV    = 4'd4;
    localparam logic [3:0] OP_MOD    = 4'd5;
    localparam logic [3:0] OP_PRINT  = 4'd6;
    localparam logic [3:0] OP_PEEK   = 4'd7;
    localparam logic [3:0] OP_DUP    = 4'd8;
    localparam logic [3:0] OP_SWAP   = 4'd9;
    localparam logic [3:0] OP_CLEAR  = 4'd10;
    localparam logic [3:0] OP_RECALL = 4'd11;
    localparam logic [3:0] OP_ASSIGN = 4'd12;
    localparam logic [3:0] OP_LAST   = 4'd13;
    localparam logic [3:0] OP_UNSET  = 4'd14;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_NOVAR = 3'd4;

    // push sources
    localparam logic [3:0] SRC_OPERAND = 4'd0;
    localparam logic [3:0] SRC_X       = 4'd1;
    localparam logic [3:0] SRC_Y       = 4'd2;
    localparam logic [3:0] SRC_ADD     = 4'd3;
    localparam logic [3:0] SRC_SUB     = 4'd4;
    localparam logic [3:0] SRC_MUL     = 4'd5;
    localparam logic [3:0] SRC_DIV     = 4'd6;
    localparam logic [3:0] SRC_MOD     = 4'd7;
    localparam logic [3:0] SRC_VAR     = 4'd8;
    localparam logic [3:0] SRC_LAST    = 4'd9;

    typedef struct packed {
        logic       load;
        logic       pop;
        logic       top;
        logic       top_pop;
        logic       cap_x;
        logic       cap_y;
        logic       push;
        logic [3:0] push_src;
        logic       flag;
        logic [2:0] flag_code;
        logic       clear;
        logic       recall;
        logic       unset;
        logic       mul;
        logic       div_start;
        logic       div_mod;
        logic       show;
        logic       assign_var;
    } rpn_cmd_t;

    typedef struct packed {
        logic depth_zero;
        logic sel_valid;
        logic vidx_bad;
        logic x_zero;
        logic div_done;
    } rpn_stat_t;

endpackage

// ===== rtl/rpn_div.sv =====
// ----------------------------------------------------------------------------
// rpn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpn_pkg::QuoW-1:0]   dividend,
    input  logic [rpn_pkg::DataW-1:0]  divisor,
    output logic                       done,
    output logic [rpn_pkg::QuoW-1:0]   quotient,
    output logic [rpn_pkg::DataW-1:0]  remainder
);

    logic [rpn_pkg::QuoW-1:0]    quo_reg;
    logic [rpn_pkg::DataW-1:0]   rem_reg;
    logic [rpn_pkg::DataW-1:0]   dvs_reg;
    logic [rpn_pkg::DivCntW-1:0] cnt_reg;
    logic                        run_reg;
    logic                        done_reg;
    logic [rpn_pkg::DataW:0]     trial;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[rpn_pkg::QuoW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rpn_pkg::DivCntW'(rpn_pkg::QuoW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[rpn_pkg::QuoW-2:0], fits};
            rem_reg <= fits ? rpn_pkg::DataW'(trial - {1'b0, dvs_reg})
                            : trial[rpn_pkg::DataW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpn_ctrl
// Opcode sequencer: steps each operation through pops, compute and pushes.
// ----------------------------------------------------------------------------
module rpn_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [3:0]          opcode,
    input  rpn_pkg::rpn_stat_t  stat,
    output rpn_pkg::rpn_cmd_t   cmd,
    output logic                busy,
    output logic                done
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_WAIT_X    = 4'd2;
    localparam logic [3:0] S_CHK0      = 4'd3;
    localparam logic [3:0] S_POP_Y     = 4'd4;
    localparam logic [3:0] S_WAIT_Y    = 4'd5;
    localparam logic [3:0] S_MUL       = 4'd6;
    localparam logic [3:0] S_DIV_GO    = 4'd7;
    localparam logic [3:0] S_DIV_WAIT  = 4'd8;
    localparam logic [3:0] S_PUSH_R    = 4'd9;
    localparam logic [3:0] S_PUSH_X1   = 4'd10;
    localparam logic [3:0] S_PUSH_2ND  = 4'd11;
    localparam logic [3:0] S_ASSIGN    = 4'd12;
    localparam logic [3:0] S_SHOW      = 4'd13;
    localparam logic [3:0] S_FIN       = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [3:0] op_reg;
    logic       done_reg;
    logic       accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= rpn_pkg::OP_PUSH;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN);
            if (accept)
            begin
                op_reg <= opcode;
            end
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.load   = accept;
        cmd.div_mod = (op_reg == rpn_pkg::OP_MOD);
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                case (op_reg)
                    rpn_pkg::OP_PUSH:
                    begin
                        cmd.push     = 1'b1;
                        cmd.push_src = rpn_pkg::SRC_OPERAND;
                    end
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
                    rpn_pkg::OP_MOD, rpn_pkg::OP_SWAP, rpn_pkg::OP_DUP:
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_WAIT_X;
                    end
                    rpn_pkg::OP_ASSIGN:
                    begin
                        if (stat.sel_valid)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_WAIT_X;
                        end
                        else
                        begin
                            cmd.flag      = 1'b1;
                            cmd.flag_code = rpn_pkg::ST_NOVAR;
                        end
                    end
                    rpn_pkg::OP_PRINT, rpn_pkg::OP_PEEK:
                    begin
                        if (stat.depth_zero)
                        begin
                            cmd.flag      = 1'b1;
                            cmd.flag_code = rpn_pkg::ST_UNDER;
                        end
                        else
                        begin
                            cmd.top     = 1'b1;
                            cmd.top_pop = (op_reg == rpn_pkg::OP_PRINT);
                            state_next  = S_SHOW;
                        end
                    end
                    rpn_pkg::OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                    end
                    rpn_pkg::OP_RECALL:
                    begin
                        if (stat.vidx_bad)
                        begin
                            cmd.flag      = 1'b1;
                            cmd.flag_code = rpn_pkg::ST_NOVAR;
                        end
                        else
                        begin
                            cmd.recall   = 1'b1;
                            cmd.push     = 1'b1;
                            cmd.push_src = rpn_pkg::SRC_VAR;
                        end
                    end
                    rpn_pkg::OP_LAST:
                    begin
                        cmd.push     = 1'b1;
                        cmd.push_src = rpn_pkg::SRC_LAST;
                    end
                    rpn_pkg::OP_UNSET:
                    begin
                        cmd.unset = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WAIT_X:
            begin
                cmd.cap_x = 1'b1;
                case (op_reg)
                    rpn_pkg::OP_DUP:                 state_next = S_PUSH_X1;
                    rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: state_next = S_CHK0;
                    default:                         state_next = S_POP_Y;
                endcase
            end
            S_CHK0:
            begin
                if (stat.x_zero)
                begin
                    cmd.flag      = 1'b1;
                    cmd.flag_code = rpn_pkg::ST_DIV0;
                    state_next    = S_FIN;
                end
                else
                begin
                    state_next = S_POP_Y;
                end
            end
            S_POP_Y:
            begin
                cmd.pop    = 1'b1;
                state_next = S_WAIT_Y;
            end
            S_WAIT_Y:
            begin
                cmd.cap_y = 1'b1;
                case (op_reg)
                    rpn_pkg::OP_MUL:                 state_next = S_MUL;
                    rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: state_next = S_DIV_GO;
                    rpn_pkg::OP_SWAP:                state_next = S_PUSH_X1;
                    rpn_pkg::OP_ASSIGN:              state_next = S_ASSIGN;
                    default:                         state_next = S_PUSH_R;
                endcase
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PUSH_R;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_PUSH_R;
                end
            end
            S_PUSH_R:
            begin
                cmd.push   = 1'b1;
                state_next = S_FIN;
                case (op_reg)
                    rpn_pkg::OP_ADD: cmd.push_src = rpn_pkg::SRC_ADD;
                    rpn_pkg::OP_SUB: cmd.push_src = rpn_pkg::SRC_SUB;
                    rpn_pkg::OP_MUL: cmd.push_src = rpn_pkg::SRC_MUL;
                    rpn_pkg::OP_DIV: cmd.push_src = rpn_pkg::SRC_DIV;
                    default:         cmd.push_src = rpn_pkg::SRC_MOD;
                endcase
            end
            S_PUSH_X1:
            begin
                cmd.push     = 1'b1;
                cmd.push_src = rpn_pkg::SRC_X;
                state_next   = S_PUSH_2ND;
            end
            S_PUSH_2ND:
            begin
                // dup pushes the same value again, swap pushes the second pop
                cmd.push     = 1'b1;
                cmd.push_src = (op_reg == rpn_pkg::OP_DUP) ? rpn_pkg::SRC_X : rpn_pkg::SRC_Y;
                state_next   = S_FIN;
            end
            S_ASSIGN:
            begin
                cmd.assign_var = 1'b1;
                state_next     = S_FIN;
            end
            S_SHOW:
            begin
                cmd.show   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rpn_dp.sv =====
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath: value stack memory, variables, operand registers, arithmetic.
// ----------------------------------------------------------------------------
module rpn_dp
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rpn_pkg::rpn_cmd_t                 cmd,
    output rpn_pkg::rpn_stat_t                stat,
    input  logic signed [rpn_pkg::DataW-1:0]  operand_value,
    input  logic [rpn_pkg::VarIdxW-1:0]       var_index,
    output logic signed [rpn_pkg::DataW-1:0]  shown_value,
    output logic                              shown_valid,
    output logic [2:0]                        status
);

    localparam int DepthW = $clog2(STACK_DEPTH + 1);
    localparam int IdxW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int W      = rpn_pkg::DataW;

    logic [W-1:0]       stack_mem [STACK_DEPTH];
    logic [W-1:0]       rd_data_reg;
    logic               under_reg;
    logic [DepthW-1:0]  depth_reg;
    logic [DepthW-1:0]  depth_m1;
    logic               depth_zero;
    logic               full;

    logic [W-1:0]       var_file_reg [rpn_pkg::NumVars];
    logic [rpn_pkg::VarIdxW-1:0] sel_reg;
    logic               sel_valid_reg;
    logic [W-1:0]       last_reg;

    logic [W-1:0]       operand_reg;
    logic [rpn_pkg::VarIdxW-1:0] vidx_reg;
    logic [W-1:0]       x_reg, y_reg;
    logic [W-1:0]       shown_reg;
    logic               valid_reg;
    logic [2:0]         status_reg;

    logic signed [2*W-1:0] prod_reg;
    logic [W-1:0]       mul_sat;
    logic               neg_q_reg, neg_r_reg;
    logic [W-1:0]       a_mag;
    logic [W-1:0]       b_mag;
    logic [rpn_pkg::QuoW-1:0] dividend;
    logic [rpn_pkg::QuoW-1:0] quo;
    logic [W-1:0]       rem;
    logic               div_done;
    logic [W-1:0]       div_sat;
    logic [W-1:0]       mod_val;
    logic [W-1:0]       var_rd;
    logic [W-1:0]       push_val;
    logic               vidx_bad;

    assign depth_m1   = depth_reg - 1'b1;
    assign depth_zero = (depth_reg == '0);
    assign full       = (depth_reg >= DepthW'(STACK_DEPTH));
    assign vidx_bad   = (vidx_reg >= rpn_pkg::VarIdxW'(rpn_pkg::NumVars));
    assign var_rd     = vidx_bad ? '0 : var_file_reg[vidx_reg];

    // floor shift by 16 of the product, saturated
    always_comb
    begin
        if ((prod_reg[2*W-1:W+15] == '0) || (prod_reg[2*W-1:W+15] == '1))
        begin
            mul_sat = prod_reg[W+15:16];
        end
        else
        begin
            mul_sat = prod_reg[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
    end

    assign a_mag    = y_reg[W-1] ? (~y_reg + 1'b1) : y_reg;
    assign b_mag    = x_reg[W-1] ? (~x_reg + 1'b1) : x_reg;
    assign dividend = cmd.div_mod ? {16'd0, a_mag} : {a_mag, 16'd0};

    rpn_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (b_mag),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        if (neg_q_reg)
        begin
            if (quo > rpn_pkg::QuoW'(33'h0_8000_0000))
            begin
                div_sat = {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                div_sat = ~quo[W-1:0] + 1'b1;
            end
        end
        else if (quo > rpn_pkg::QuoW'(32'h7FFF_FFFF))
        begin
            div_sat = {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            div_sat = quo[W-1:0];
        end
    end

    assign mod_val = neg_r_reg ? (~rem + 1'b1) : rem;

    always_comb
    begin
        case (cmd.push_src)
            rpn_pkg::SRC_OPERAND: push_val = operand_reg;
            rpn_pkg::SRC_X:       push_val = x_reg;
            rpn_pkg::SRC_Y:       push_val = y_reg;
            rpn_pkg::SRC_ADD:     push_val = y_reg + x_reg;
            rpn_pkg::SRC_SUB:     push_val = y_reg - x_reg;
            rpn_pkg::SRC_MUL:     push_val = mul_sat;
            rpn_pkg::SRC_DIV:     push_val = div_sat;
            rpn_pkg::SRC_MOD:     push_val = mod_val;
            rpn_pkg::SRC_VAR:     push_val = var_rd;
            rpn_pkg::SRC_LAST:    push_val = last_reg;
            default:              push_val = '0;
        endcase
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            stack_mem[depth_reg[IdxW-1:0]] <= push_val;
        end
        if ((cmd.pop || cmd.top) && !depth_zero)
        begin
            rd_data_reg <= stack_mem[depth_m1[IdxW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            under_reg     <= 1'b0;
            status_reg    <= rpn_pkg::ST_OK;
            valid_reg     <= 1'b0;
            shown_reg     <= '0;
            last_reg      <= '0;
            sel_reg       <= '0;
            sel_valid_reg <= 1'b0;
            for (int i = 0; i < rpn_pkg::NumVars; i++)
            begin
                var_file_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                status_reg <= rpn_pkg::ST_OK;
                valid_reg  <= 1'b0;
                shown_reg  <= '0;
            end
            else if (status_reg == rpn_pkg::ST_OK)
            begin
                if (cmd.flag)
                begin
                    status_reg <= cmd.flag_code;
                end
                else if (cmd.pop && depth_zero)
                begin
                    status_reg <= rpn_pkg::ST_UNDER;
                end
                else if (cmd.push && full)
                begin
                    status_reg <= rpn_pkg::ST_FULL;
                end
            end

            if (cmd.clear)
            begin
                depth_reg <= '0;
            end
            else if ((cmd.pop || cmd.top_pop) && !depth_zero)
            begin
                depth_reg <= depth_m1;
            end
            else if (cmd.push && !full)
            begin
                depth_reg <= depth_reg + 1'b1;
            end

            if (cmd.pop)
            begin
                under_reg <= depth_zero;
            end

            if (cmd.recall)
            begin
                sel_reg       <= vidx_reg;
                sel_valid_reg <= 1'b1;
            end

            if (cmd.show)
            begin
                shown_reg <= rd_data_reg;
                valid_reg <= 1'b1;
                last_reg  <= rd_data_reg;
            end

            if (cmd.assign_var)
            begin
                var_file_reg[sel_reg] <= y_reg;
                shown_reg             <= y_reg;
                valid_reg             <= 1'b1;
                last_reg              <= y_reg;
                sel_valid_reg         <= 1'b0;
            end

            if (cmd.unset)
            begin
                last_reg <= '0;
                for (int i = 0; i < rpn_pkg::NumVars; i++)
                begin
                    var_file_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            operand_reg <= operand_value;
            vidx_reg    <= var_index;
        end
        // an underflowed pop reads as zero
        if (cmd.cap_x)
        begin
            x_reg <= under_reg ? '0 : rd_data_reg;
        end
        if (cmd.cap_y)
        begin
            y_reg <= under_reg ? '0 : rd_data_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= $signed(y_reg) * $signed(x_reg);
        end
        if (cmd.div_start)
        begin
            neg_q_reg <= y_reg[W-1] ^ x_reg[W-1];
            neg_r_reg <= y_reg[W-1];
        end
    end

    assign stat.depth_zero = depth_zero;
    assign stat.sel_valid  = sel_valid_reg;
    assign stat.vidx_bad   = vidx_bad;
    assign stat.x_zero     = (x_reg == '0);
    assign stat.div_done   = div_done;

    assign shown_value = shown_reg;
    assign shown_valid = valid_reg;
    assign status      = status_reg;

endmodule

// ===== rtl/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish stack engine on signed Q16.16 values.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  command   | start / busy       | opcode, operand_value, var_index
//  result    | done (1-cycle)     | shown_value, shown_valid, status
//
//  one opcode at a time; div and mod wait on the 48-step divider
//  each stack pop is a registered memory read followed by a capture into x or y
//  reset empties the stack, zeroes variables, last value and selection
//  done is high for one cycle; the receiver must take it then
// ----------------------------------------------------------------------------
module rpn_stack_calculator
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [3:0]                        opcode,
    input  logic signed [rpn_pkg::DataW-1:0]  operand_value,
    input  logic [rpn_pkg::VarIdxW-1:0]       var_index,
    output logic                              done,
    output logic signed [rpn_pkg::DataW-1:0]  shown_value,
    output logic                              shown_valid,
    output logic [2:0]                        status
);

    rpn_pkg::rpn_cmd_t  cmd;
    rpn_pkg::rpn_stat_t stat;

    rpn_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rpn_dp
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operand_value (operand_value),
        .var_index     (var_index),
        .shown_value   (shown_value),
        .shown_valid   (shown_valid),
        .status        (status)
    );

endmodule
